@@ rtl/core/ppv_pkg.sv @@
// ============================================================================
// ppv_pkg
// Shared types, character constants and helper functions for the portable
// relative path validator.
// ============================================================================
package ppv_pkg;

    localparam int unsigned LEN_W = 12;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 12'd240;
    localparam logic [LEN_W-1:0] COUNT_MAX        = {LEN_W{1'b1}};

    // Character constants
    localparam logic [7:0] CH_PRINT_LOW  = 8'h20;
    localparam logic [7:0] CH_PRINT_HIGH = 8'h7e;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DOT        = 8'h2e;
    localparam logic [7:0] CH_SLASH      = 8'h2f;
    localparam logic [7:0] CH_BSLASH     = 8'h5c;
    localparam logic [7:0] CH_LT         = 8'h3c;
    localparam logic [7:0] CH_GT         = 8'h3e;
    localparam logic [7:0] CH_COLON      = 8'h3a;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_PIPE       = 8'h7c;
    localparam logic [7:0] CH_QUESTION   = 8'h3f;
    localparam logic [7:0] CH_STAR       = 8'h2a;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7a;
    localparam logic [7:0] CH_DIGIT_1    = 8'h31;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Reserved device names
    localparam logic [23:0] DEV_CON = "CON";
    localparam logic [23:0] DEV_PRN = "PRN";
    localparam logic [23:0] DEV_AUX = "AUX";
    localparam logic [23:0] DEV_NUL = "NUL";
    localparam logic [23:0] DEV_COM = "COM";
    localparam logic [23:0] DEV_LPT = "LPT";

    localparam logic [1:0] COMP_LEN_MAX = 2'd3;
    localparam logic [2:0] STEM_KEEP    = 3'd4;
    localparam logic [2:0] STEM_LEN_MAX = 3'd5;

    typedef enum logic [2:0] {
        REASON_OK        = 3'd0,
        REASON_LENGTH    = 3'd1,
        REASON_ABSOLUTE  = 3'd2,
        REASON_DOT_COMP  = 3'd3,
        REASON_TRAILING  = 3'd4,
        REASON_RESERVED  = 3'd5,
        REASON_BAD_CHAR  = 3'd6
    } reason_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } item_t;

    typedef logic [3:0][7:0] stem_t;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SLASH) || (c == CH_BSLASH);
    endfunction

    function automatic logic is_bad(input logic [7:0] c);
        return (c < CH_PRINT_LOW) || (c > CH_PRINT_HIGH) || (c == CH_LT) ||
               (c == CH_GT) || (c == CH_COLON) || (c == CH_QUOTE) ||
               (c == CH_PIPE) || (c == CH_QUESTION) || (c == CH_STAR);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ? (c - CASE_OFFSET) : c;
    endfunction

    function automatic logic stem_reserved(input stem_t s, input logic [2:0] len);
        logic [23:0] head;
        head = {s[0], s[1], s[2]};
        if (len == 3'd3) begin
            return (head == DEV_CON) || (head == DEV_PRN) ||
                   (head == DEV_AUX) || (head == DEV_NUL);
        end
        if ((len == 3'd4) && (s[3] >= CH_DIGIT_1) && (s[3] <= CH_DIGIT_9)) begin
            return (head == DEV_COM) || (head == DEV_LPT);
        end
        return 1'b0;
    endfunction

    // Verdict on a component that has just ended
    function automatic reason_t close_comp(input logic [1:0] len, input logic all_dots,
                                           input logic [7:0] prev, input stem_t s,
                                           input logic [2:0] slen);
        if ((len == 2'd0) || (all_dots && (len <= 2'd2))) begin
            return REASON_DOT_COMP;
        end
        if ((prev == CH_SPACE) || (prev == CH_DOT)) begin
            return REASON_TRAILING;
        end
        if (stem_reserved(s, slen)) begin
            return REASON_RESERVED;
        end
        return REASON_OK;
    endfunction

endpackage

@@ rtl/core/ppv_in_reg.sv @@
// ============================================================================
// ppv_in_reg
// Input register: captures one request and holds it until the scan stage
// takes it.
// ============================================================================
module ppv_in_reg
    import ppv_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    // free slot, or the held request leaves this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                item_next = s_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/core/ppv_scan.sv @@
// ============================================================================
// ppv_scan
// Running path state: byte count, first fault and the component being
// collected; forms the verdict on the closing request.
// ============================================================================
module ppv_scan
    import ppv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  item_t            item,
    input  logic [LEN_W-1:0] max_length,
    output reason_t          verdict
);

    logic [LEN_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    reason_t          err_reg, err_next;
    logic [1:0]       clen_reg, clen_next;
    logic             dots_reg, dots_next;
    logic [7:0]       prev_reg, prev_next;
    stem_t            stem_reg, stem_next;
    logic [2:0]       slen_reg, slen_next;
    logic             closed_reg, closed_next;

    logic             first;
    logic [7:0]       c;

    always_comb begin
        c           = item.ch;
        first       = (count_reg == '0) && !ovf_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        err_next    = err_reg;
        clen_next   = clen_reg;
        dots_next   = dots_reg;
        prev_next   = prev_reg;
        stem_next   = stem_reg;
        slen_next   = slen_reg;
        closed_next = closed_reg;

        if (item.has_char) begin
            // saturate the count, flag overflow past the top
            if (!ovf_reg) begin
                if (count_reg == COUNT_MAX) begin
                    ovf_next = 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            if (err_reg == REASON_OK) begin
                if (is_sep(c)) begin
                    err_next    = first ? REASON_ABSOLUTE
                                        : close_comp(clen_reg, dots_reg, prev_reg,
                                                     stem_reg, slen_reg);
                    clen_next   = 2'd0;
                    dots_next   = 1'b1;
                    prev_next   = 8'd0;
                    stem_next   = '0;
                    slen_next   = 3'd0;
                    closed_next = 1'b0;
                end else if (is_bad(c)) begin
                    err_next = REASON_BAD_CHAR;
                end else begin
                    if (clen_reg != COMP_LEN_MAX) begin
                        clen_next = clen_reg + 1'b1;
                    end
                    if (c != CH_DOT) begin
                        dots_next = 1'b0;
                    end
                    prev_next = c;
                    if (!closed_reg) begin
                        if (c == CH_DOT) begin
                            closed_next = 1'b1;
                        end else begin
                            if (slen_reg < STEM_KEEP) begin
                                stem_next[slen_reg[1:0]] = to_upper(c);
                            end
                            if (slen_reg != STEM_LEN_MAX) begin
                                slen_next = slen_reg + 1'b1;
                            end
                        end
                    end
                end
            end
        end

        priority if ((count_next == '0) && !ovf_next) begin
            verdict = REASON_LENGTH;
        end else if (ovf_next || (count_next > max_length)) begin
            verdict = REASON_LENGTH;
        end else if (err_next != REASON_OK) begin
            verdict = err_next;
        end else begin
            verdict = close_comp(clen_next, dots_next, prev_next, stem_next, slen_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && item.last)) begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            err_reg    <= REASON_OK;
            clen_reg   <= 2'd0;
            dots_reg   <= 1'b1;
            prev_reg   <= 8'd0;
            stem_reg   <= '0;
            slen_reg   <= 3'd0;
            closed_reg <= 1'b0;
        end else if (advance) begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            err_reg    <= err_next;
            clen_reg   <= clen_next;
            dots_reg   <= dots_next;
            prev_reg   <= prev_next;
            stem_reg   <= stem_next;
            slen_reg   <= slen_next;
            closed_reg <= closed_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.last) |=> (count_reg == '0) && !ovf_reg && (err_reg == REASON_OK))
        else $error("path state not cleared after verdict");

    a_overflow_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == COUNT_MAX))
        else $error("overflow flagged below saturated count");

    a_empty_component: assert property (@(posedge aclk) disable iff (!aresetn)
        (clen_reg == 2'd0) |-> (dots_reg && (slen_reg == 3'd0) && !closed_reg))
        else $error("empty component carries stem or dot state");
`endif

endmodule

@@ rtl/core/portable_path_validator_top.sv @@
// ============================================================================
// portable_path_validator_top
// Relative path validator: one path byte per request, one verdict per path.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  s_      | in        | s_valid / s_ready    | s_ch[7:0], s_has_char, s_last
//  m_      | out       | m_valid / m_ready    | m_ok, m_reason_code[2:0]
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_wdata[11:0] (max_length)
//
//  Throughput is one request per cycle while no closing request stalls;
//  the running path state is updated in a single pass between the input
//  register and the result register. m_valid rises once the request
//  carrying s_last has left the input register for the result register.
//  Reset (aresetn low, synchronous) empties both registers, clears the path
//  state and sets max_length to 240.
//  A waiting verdict holds the result register; only a request carrying
//  s_last then stalls, byte requests keep flowing. cfg_ready is always high.
//
module portable_path_validator_top
    import ppv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // path bytes
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_ch,
    input  logic             s_has_char,
    input  logic             s_last,
    // verdicts
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_ok,
    output logic [2:0]       m_reason_code,
    // max_length register write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_wdata
);

    item_t            s_item;
    item_t            item;
    logic             item_valid;
    logic             advance;
    reason_t          verdict;

    logic [LEN_W-1:0] max_len_reg, max_len_next;
    logic             out_valid_reg, out_valid_next;
    logic             ok_reg, ok_next;
    reason_t          reason_reg, reason_next;

    assign s_item = '{ch: s_ch, has_char: s_has_char, last: s_last};

    // a closing request needs room in the result register
    assign advance = item_valid && (!item.last || !out_valid_reg || m_ready);

    ppv_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ppv_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item       (item),
        .max_length (max_len_reg),
        .verdict    (verdict)
    );

    // configuration: accept every write, keep the low twelve bits
    assign cfg_ready    = 1'b1;
    assign max_len_next = (cfg_valid && cfg_ready) ? cfg_wdata : max_len_reg;

    // result register: load on a closing request, drop when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        reason_next    = reason_reg;
        if (advance && item.last) begin
            out_valid_next = 1'b1;
            ok_next        = (verdict == REASON_OK);
            reason_next    = verdict;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= MAX_LENGTH_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            max_len_reg   <= max_len_next;
            out_valid_reg <= out_valid_next;
        end
        ok_reg     <= ok_next;
        reason_reg <= reason_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_ok          = ok_reg;
    assign m_reason_code = reason_reg;

`ifndef SYNTHESIS
    a_verdict_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.last) |=> m_valid)
        else $error("closing request produced no verdict");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item.last && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while closing request is stalled");

    a_verdict_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_ok) && $stable(m_reason_code)))
        else $error("waiting verdict changed before it was taken");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Path validator testbench
// Streams relative paths one byte per request into the validator and checks
// every verdict against a cycle-free predictor of the path rules, over a
// range of max_length settings, with random input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import ppv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 4;

    // One stimulus request, with an optional hand-written verdict
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
        logic       typed;
        logic       ok;
        reason_t    reason;
    } row_t;

    typedef struct packed {
        logic    ok;
        reason_t reason;
    } verdict_t;

    // Clock, reset and DUT ports; every input starts at a known value
    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [7:0]       s_ch          = 8'h00;
    logic             s_has_char    = 1'b0;
    logic             s_last        = 1'b0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic             m_ok;
    logic [2:0]       m_reason_code;
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_wdata     = '0;

    // Predictor state: a private copy of the running path registers
    logic [LEN_W-1:0] length_limit;
    logic [LEN_W-1:0] path_len;
    logic             len_overflow;
    reason_t          path_fault;
    logic [1:0]       seg_len;
    logic             seg_dots;
    logic [7:0]       seg_tail;
    logic [7:0]       stem [4];
    logic [2:0]       stem_len;
    logic             stem_done;

    verdict_t         verdicts_due [$];
    verdict_t         head_verdict;
    logic [7:0]       path_buf [$];
    row_t             directed_rows [DIRECTED_ROWS];
    logic [LEN_W-1:0] phase_limit [PHASES];

    int unsigned      mismatches = 0;
    int unsigned      items_sent = 0;
    int unsigned      phase_end;
    int unsigned      paths_in_phase;
    logic             calm = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    portable_path_validator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_has_char    (s_has_char),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_reason_code (m_reason_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Drop everything learnt about the component in progress
    task automatic clear_segment();
        seg_len   = 2'd0;
        seg_dots  = 1'b1;
        seg_tail  = 8'h00;
        for (int i = 0; i < 4; i++) begin
            stem[i] = 8'h00;
        end
        stem_len  = 3'd0;
        stem_done = 1'b0;
    endtask

    task automatic clear_path_state();
        path_len     = '0;
        len_overflow = 1'b0;
        path_fault   = REASON_OK;
        clear_segment();
    endtask

    function automatic logic forbidden_byte(input logic [7:0] c);
        case (c)
            CH_LT, CH_GT, CH_COLON, CH_QUOTE, CH_PIPE, CH_QUESTION, CH_STAR: return 1'b1;
            default: return (c < 8'h20) || (c > 8'h7e);
        endcase
    endfunction

    // Does the stem (part before the first dot) name a DOS device?
    function automatic logic names_device();
        logic [23:0] head;
        logic        numbered;
        head     = {stem[0], stem[1], stem[2]};
        numbered = (stem[3] >= "1") && (stem[3] <= "9");
        case (stem_len)
            3'd3:    return (head == DEV_CON) || (head == DEV_PRN) ||
                            (head == DEV_AUX) || (head == DEV_NUL);
            3'd4:    return numbered && ((head == DEV_COM) || (head == DEV_LPT));
            default: return 1'b0;
        endcase
    endfunction

    // Fault, if any, of the component that ends here
    function automatic reason_t segment_fault();
        if (seg_len == 2'd0 || (seg_dots && seg_len != 2'd3)) begin
            return REASON_DOT_COMP;
        end
        if (seg_tail == " " || seg_tail == ".") begin
            return REASON_TRAILING;
        end
        if (names_device()) begin
            return REASON_RESERVED;
        end
        return REASON_OK;
    endfunction

    task automatic absorb_byte(input logic [7:0] c);
        logic leading;
        leading = (path_len == '0) && !len_overflow;
        // Saturate the length; one byte past the top marks the overflow
        if (!len_overflow) begin
            if (path_len == COUNT_MAX) begin
                len_overflow = 1'b1;
            end else begin
                path_len = path_len + 1'b1;
            end
        end
        if (path_fault != REASON_OK) begin
            return;
        end
        if (c == CH_SLASH || c == CH_BSLASH) begin
            path_fault = leading ? REASON_ABSOLUTE : segment_fault();
            clear_segment();
        end else if (forbidden_byte(c)) begin
            path_fault = REASON_BAD_CHAR;
        end else begin
            if (seg_len != 2'd3) begin
                seg_len = seg_len + 1'b1;
            end
            if (c != ".") begin
                seg_dots = 1'b0;
            end
            seg_tail = c;
            if (!stem_done) begin
                if (c == ".") begin
                    stem_done = 1'b1;
                end else begin
                    if (stem_len < 3'd4) begin
                        stem[stem_len[1:0]] = (c >= "a" && c <= "z") ? c - 8'h20 : c;
                    end
                    if (stem_len < 3'd5) begin
                        stem_len = stem_len + 1'b1;
                    end
                end
            end
        end
    endtask

    // Advance the predictor by one request; a verdict falls out on last
    task automatic step_path(input logic [7:0] c, input logic has_char, input logic last,
                             output logic emitted, output verdict_t v);
        reason_t r;
        if (has_char) begin
            absorb_byte(c);
        end
        emitted = last;
        v       = '{1'b0, REASON_OK};
        if (last) begin
            if (len_overflow || path_len == '0 || path_len > length_limit) begin
                r = REASON_LENGTH;
            end else if (path_fault != REASON_OK) begin
                r = path_fault;
            end else begin
                r = segment_fault();
            end
            v = '{(r == REASON_OK), r};
            clear_path_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Mostly no gap, sometimes a few cycles, rarely a long stall
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic row_t byte_row(input logic [7:0] c, input logic h, input logic l);
        return '{c, h, l, 1'b0, 1'b0, REASON_OK};
    endfunction

    // Offer one request, hold it until taken, then predict
    task automatic send_item(input row_t r);
        int       gap;
        logic     emitted;
        verdict_t v;
        s_valid    <= 1'b1;
        s_ch       <= r.ch;
        s_has_char <= r.has_char;
        s_last     <= r.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        step_path(r.ch, r.has_char, r.last, emitted, v);
        if (emitted) begin
            if (r.typed) begin
                verdicts_due.insert(verdicts_due.size(), '{r.ok, r.reason});
            end else begin
                verdicts_due.insert(verdicts_due.size(), v);
            end
        end
        if (r.has_char || r.last) begin
            items_sent++;
        end
        gap = calm ? 0 : idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the sender until every verdict is in and the pipeline is empty
    task automatic drain_verdicts();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        length_limit = value;
        cfg_valid   <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Path generation
    // ------------------------------------------------------------------------

    // Append one byte to the path being built
    task automatic append_byte(input logic [7:0] c);
        path_buf.insert(path_buf.size(), c);
    endtask

    function automatic logic [7:0] name_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return (r == 62) ? 8'("-") : 8'("_");
    endfunction

    function automatic logic [7:0] separator();
        return $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
    endfunction

    function automatic logic [7:0] illegal_char();
        case ($urandom_range(0, 8))
            0: return CH_LT;
            1: return CH_GT;
            2: return CH_COLON;
            3: return CH_QUOTE;
            4: return CH_PIPE;
            5: return CH_QUESTION;
            6: return CH_STAR;
            7: return 8'($urandom_range(0, 31));
            default: return 8'($urandom_range(127, 255));
        endcase
    endfunction

    task automatic push_name(input int len);
        for (int i = 0; i < len; i++) begin
            append_byte(name_char());
        end
    endtask

    // A device name in random case, sometimes with a suffix or extension
    task automatic push_device();
        logic [23:0] base;
        logic [7:0]  c;
        int          n;
        case ($urandom_range(0, 5))
            0: base = DEV_CON;
            1: base = DEV_PRN;
            2: base = DEV_AUX;
            3: base = DEV_NUL;
            4: base = DEV_COM;
            default: base = DEV_LPT;
        endcase
        n = (base == DEV_COM || base == DEV_LPT) ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            c = (i < 3) ? base[23 - 8*i -: 8] : 8'("0" + $urandom_range(0, 9));
            if ($urandom_range(0, 1)) begin
                c = c | 8'h20;
            end
            append_byte(c);
        end
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                append_byte(".");
                push_name($urandom_range(1, 3));
            end
            3:       push_name(1);
            default: ;
        endcase
    endtask

    task automatic push_component();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            push_name($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0) begin
                append_byte(".");
                push_name($urandom_range(1, 3));
            end
        end else if (r < 62) begin
            push_device();
        end else if (r < 74) begin
            // empty, dot-only and hidden names
            case ($urandom_range(0, 4))
                0: ;
                1: append_byte(".");
                2: repeat (2) append_byte(".");
                3: repeat (3) append_byte(".");
                default: begin
                    append_byte(".");
                    push_name($urandom_range(1, 4));
                end
            endcase
        end else if (r < 84) begin
            push_name($urandom_range(1, 4));
            append_byte($urandom_range(0, 1) ? 8'(" ") : 8'("."));
        end else if (r < 95) begin
            push_name($urandom_range(0, 3));
            append_byte(illegal_char());
            push_name($urandom_range(0, 2));
        end else begin
            repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed paths of a few components; the rest is raw noise
    task automatic build_path();
        int ncomp;
        path_buf.delete();
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(0, 8)) append_byte(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                append_byte(separator());
            end
            ncomp = $urandom_range(1, 4);
            for (int i = 0; i < ncomp; i++) begin
                if (i > 0) begin
                    append_byte(separator());
                end
                push_component();
            end
            if ($urandom_range(0, 19) == 0) begin
                append_byte(separator());
            end
        end
    endtask

    // Send the buffered path; close it on the last byte or by a bare request
    task automatic send_path();
        logic bare_end;
        int   n;
        n        = path_buf.size();
        bare_end = (n == 0) || ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(byte_row(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            end
            send_item(byte_row(path_buf[i], 1'b1, !bare_end && (i == n - 1)));
        end
        if (bare_end) begin
            send_item(byte_row(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        end
    endtask

    task automatic send_long_path(input int len);
        for (int i = 0; i < len; i++) begin
            send_item(byte_row(8'("a" + $urandom_range(0, 25)), 1'b1, i == len - 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Compare each accepted verdict with the oldest one due
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("verdict with none due", m_reason_code, -1);
            end else begin
                head_verdict = verdicts_due.pop_front();
                if (m_ok !== head_verdict.ok) begin
                    report_mismatch("ok", m_ok, head_verdict.ok);
                end
                if (m_reason_code !== head_verdict.reason) begin
                    report_mismatch("reason_code", m_reason_code, head_verdict.reason);
                end
            end
        end
    end

    // Receiver back-pressure: runs of ready broken by stalls of random length
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_ready <= 1'b0;
                repeat (idle_cycles() + 1) @(posedge aclk);
            end
        end
    end

    // Watchdog: a hung handshake must not keep the run alive
    initial begin
        #(20_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Directed table: typed verdicts where the rule is obvious, the rest
        // left to the predictor
        directed_rows = '{
            '{8'hff,      1'b0, 1'b0, 1'b0, 1'b0, REASON_OK},        // bare, no last
            '{8'h00,      1'b0, 1'b1, 1'b1, 1'b0, REASON_LENGTH},    // empty path
            '{CH_SLASH,   1'b1, 1'b1, 1'b1, 1'b0, REASON_ABSOLUTE},  // "/"
            '{"a",        1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{CH_SLASH,   1'b1, 1'b1, 1'b1, 1'b0, REASON_DOT_COMP},  // trailing sep
            '{8'h00,      1'b1, 1'b1, 1'b1, 1'b0, REASON_BAD_CHAR},  // lowest byte
            '{8'h7e,      1'b1, 1'b1, 1'b1, 1'b1, REASON_OK},        // top printable
            '{8'hff,      1'b1, 1'b1, 1'b1, 1'b0, REASON_BAD_CHAR},  // highest byte
            '{".",        1'b1, 1'b1, 1'b1, 1'b0, REASON_DOT_COMP},
            '{".",        1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{".",        1'b1, 1'b1, 1'b1, 1'b0, REASON_DOT_COMP},  // ".."
            '{"a",        1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{" ",        1'b1, 1'b1, 1'b1, 1'b0, REASON_TRAILING},  // "a "
            '{"c",        1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{"o",        1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{"n",        1'b1, 1'b1, 1'b1, 1'b0, REASON_RESERVED},  // "con"
            '{"L",        1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{"p",        1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{"t",        1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{"9",        1'b1, 1'b1, 1'b1, 1'b0, REASON_RESERVED},  // "Lpt9"
            '{"x",        1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{CH_BSLASH,  1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{"y",        1'b1, 1'b1, 1'b0, 1'b0, REASON_OK},        // "x\y"
            '{CH_STAR,    1'b1, 1'b0, 1'b0, 1'b0, REASON_OK},
            '{"a",        1'b1, 1'b1, 1'b1, 1'b0, REASON_BAD_CHAR}   // byte after fault
        };

        // Limits per phase: extremes, a zero, small ones and random ones
        phase_limit = '{12'd1, 12'd0, COUNT_MAX, 12'd6, 12'($urandom_range(1, 4095)),
                        12'd16, MAX_LENGTH_RESET, 12'($urandom_range(2, 40))};

        length_limit = MAX_LENGTH_RESET;
        clear_path_state();

        // Hold reset, then release it once
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part runs on the reset value of max_length
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_item(directed_rows[i]);
        end

        phase_end = items_sent;
        for (int p = 0; p < PHASES; p++) begin
            drain_verdicts();
            write_max_length(phase_limit[p]);
            calm = (p == 3);
            // At a small limit, push a path of exactly the limit and one past it
            if (phase_limit[p] == 12'd16) begin
                calm = 1'b1;
                send_long_path(int'(phase_limit[p]));
                send_long_path(int'(phase_limit[p]) + 1);
                calm = 1'b0;
            end
            phase_end      = items_sent + PHASE_ITEMS;
            paths_in_phase = 0;
            while (items_sent < phase_end) begin
                // Advance only after every verdict has landed, now and then
                if ((p == 0 && paths_in_phase == 3) || $urandom_range(0, 49) == 0) begin
                    drain_verdicts();
                end
                build_path();
                send_path();
                paths_in_phase++;
            end
        end
        calm = 1'b0;

        // Wait out the last verdicts and allow for a stray one
        drain_verdicts();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
